// ===== sv/bbs_pkg.sv =====
// Shared types and constants for the bounded byte stack.
// Depends on nothing; every other file of the block but bbs_ram uses it.
`timescale 1ns / 1ps
`default_nettype none

package bbs_pkg;

  localparam int DEPTH  = 64;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CAP_W  = 7;
  localparam int CMD_W  = 3;
  localparam int DATA_W = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH      = 3'd0,
    CMD_POP       = 3'd1,
    CMD_PEEK      = 3'd2,
    CMD_DUMP_DOWN = 3'd3,
    CMD_DUMP_UP   = 3'd4
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  // Write request from the controller to the entry memory.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } mem_wr_t;

  // Read request; last marks the final result of a peek or dump.
  typedef struct packed {
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic              last;
  } rd_issue_t;

  // Output queue status seen by the controller.
  typedef struct packed {
    logic room;
  } q_status_t;

endpackage

`default_nettype wire

// ===== sv/bbs_if.sv =====
// Handshake channels of the bounded byte stack: command input and result output.
// Depends on bbs_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface bbs_cmd_if;
  logic                           valid;
  logic                           ready;
  logic [bbs_pkg::CMD_W-1:0]      command;
  logic [bbs_pkg::DATA_W-1:0]     push_value;

  modport source (output valid, output command, output push_value, input ready);
  modport sink   (input valid, input command, input push_value, output ready);
endinterface

interface bbs_res_if;
  logic                           valid;
  logic                           ready;
  logic [bbs_pkg::DATA_W-1:0]     item;
  logic                           last;

  modport source (output valid, output item, output last, input ready);
  modport sink   (input valid, input item, input last, output ready);
endinterface

`default_nettype wire

// ===== sv/bbs_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

module bbs_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/bbs_outq.sv =====
// Two-entry result queue fed by the entry memory's read port.
// Depends on bbs_pkg and the bbs_res_if channel.
`timescale 1ns / 1ps
`default_nettype none

module bbs_outq (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire bbs_pkg::rd_issue_t         issue,
  input  wire logic [bbs_pkg::DATA_W-1:0] rdata,
  bbs_res_if.source                       out_ch,
  output bbs_pkg::q_status_t              status
);

  logic                       inflight_r, inflight_nxt;
  logic                       inlast_r;
  logic [1:0]                 occ_r, occ_nxt;
  logic [bbs_pkg::DATA_W-1:0] h_item_r, h_item_nxt, t_item_r, t_item_nxt;
  logic                       h_last_r, h_last_nxt, t_last_r, t_last_nxt;
  logic                       pop;
  logic                       push;
  logic [2:0]                 pending;

  assign pop          = (occ_r != 2'd0) && out_ch.ready;
  assign push         = inflight_r;
  assign inflight_nxt = issue.re;

  // Slots taken after this cycle, counting the read still in the memory.
  assign pending     = {1'b0, occ_r} + {2'b00, inflight_r} - {2'b00, pop};
  assign status.room = pending < 3'd2;

  always_comb begin
    occ_nxt    = occ_r + {1'b0, push} - {1'b0, pop};
    h_item_nxt = h_item_r;
    h_last_nxt = h_last_r;
    t_item_nxt = t_item_r;
    t_last_nxt = t_last_r;
    if (pop) begin
      if (occ_r == 2'd2) begin
        h_item_nxt = t_item_r;
        h_last_nxt = t_last_r;
        if (push) begin
          t_item_nxt = rdata;
          t_last_nxt = inlast_r;
        end
      end else if (push) begin
        h_item_nxt = rdata;
        h_last_nxt = inlast_r;
      end
    end else if (push) begin
      if (occ_r == 2'd0) begin
        h_item_nxt = rdata;
        h_last_nxt = inlast_r;
      end else begin
        t_item_nxt = rdata;
        t_last_nxt = inlast_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= 1'b0;
      occ_r      <= 2'd0;
    end else begin
      inflight_r <= inflight_nxt;
      occ_r      <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    inlast_r <= issue.last;
    h_item_r <= h_item_nxt;
    h_last_r <= h_last_nxt;
    t_item_r <= t_item_nxt;
    t_last_r <= t_last_nxt;
  end

  assign out_ch.valid = occ_r != 2'd0;
  assign out_ch.item  = h_item_r;
  assign out_ch.last  = h_last_r;

endmodule

`default_nettype wire

// ===== sv/bbs_ctrl.sv =====
// Command decoder, fill counter, capacity register and read sequencer.
// Depends on bbs_pkg and the bbs_cmd_if channel.
`timescale 1ns / 1ps
`default_nettype none

module bbs_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  bbs_cmd_if.sink                        in_ch,
  input  wire logic                      cfg_we,
  input  wire logic [bbs_pkg::CAP_W-1:0] cfg_wdata,
  input  wire bbs_pkg::q_status_t        status,
  output bbs_pkg::mem_wr_t               wr,
  output bbs_pkg::rd_issue_t             issue
);

  bbs_pkg::state_t            state_r, state_nxt;
  logic [bbs_pkg::CNT_W-1:0]  fill_r, fill_nxt, fill_dec, cap_eff;
  logic [bbs_pkg::CAP_W-1:0]  cap_r;
  logic [bbs_pkg::ADDR_W-1:0] addr_r, addr_nxt;
  logic [bbs_pkg::CNT_W-1:0]  remain_r, remain_nxt;
  logic                       down_r, down_nxt;
  logic                       accept;
  logic                       start_read;
  bbs_pkg::cmd_t              cmd;

  assign accept   = in_ch.valid && in_ch.ready;
  assign cmd      = bbs_pkg::cmd_t'(in_ch.command);
  assign fill_dec = fill_r - 1'b1;
  assign cap_eff  = (cap_r > bbs_pkg::CAP_W'(bbs_pkg::DEPTH)) ?
                    bbs_pkg::CNT_W'(bbs_pkg::DEPTH) : bbs_pkg::CNT_W'(cap_r);

  always_comb begin
    start_read = 1'b0;
    if (accept && (fill_r != '0)) begin
      unique case (cmd) inside
        bbs_pkg::CMD_PEEK, bbs_pkg::CMD_DUMP_DOWN, bbs_pkg::CMD_DUMP_UP: begin
          start_read = 1'b1;
        end
        default: begin
          start_read = 1'b0;
        end
      endcase
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bbs_pkg::ST_IDLE: begin
        if (start_read) begin
          state_nxt = bbs_pkg::ST_READ;
        end
      end
      bbs_pkg::ST_READ: begin
        if (status.room && (remain_r == bbs_pkg::CNT_W'(1))) begin
          state_nxt = bbs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bbs_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs. Input is always ready while idle, so an offered push is taken.
  always_comb begin
    in_ch.ready = 1'b0;
    wr.we       = 1'b0;
    wr.addr     = fill_r[bbs_pkg::ADDR_W-1:0];
    wr.data     = in_ch.push_value;
    issue.re    = 1'b0;
    issue.addr  = addr_r;
    issue.last  = remain_r == bbs_pkg::CNT_W'(1);
    unique case (state_r)
      bbs_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        wr.we       = in_ch.valid && (cmd == bbs_pkg::CMD_PUSH) && (fill_r < cap_eff);
      end
      bbs_pkg::ST_READ: begin
        issue.re = status.room;
      end
      default: begin
        in_ch.ready = 1'b0;
      end
    endcase
  end

  // Fill count and read sequencer registers.
  always_comb begin
    fill_nxt   = fill_r;
    addr_nxt   = addr_r;
    remain_nxt = remain_r;
    down_nxt   = down_r;
    if (wr.we) begin
      fill_nxt = fill_r + 1'b1;
    end
    if (accept && (cmd == bbs_pkg::CMD_POP) && (fill_r != '0)) begin
      fill_nxt = fill_dec;
    end
    if (start_read) begin
      down_nxt   = cmd != bbs_pkg::CMD_DUMP_UP;
      addr_nxt   = (cmd == bbs_pkg::CMD_DUMP_UP) ? '0 : fill_dec[bbs_pkg::ADDR_W-1:0];
      remain_nxt = (cmd == bbs_pkg::CMD_PEEK) ? bbs_pkg::CNT_W'(1) : fill_r;
    end
    if (issue.re) begin
      remain_nxt = remain_r - 1'b1;
      addr_nxt   = down_r ? addr_r - 1'b1 : addr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= bbs_pkg::ST_IDLE;
      fill_r   <= '0;
      cap_r    <= bbs_pkg::CAP_W'(64);
      remain_r <= '0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      remain_r <= remain_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    down_r <= down_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/bounded_byte_stack.sv =====
// Top level of the bounded byte stack: controller, entry memory and result queue.
// Depends on bbs_pkg, bbs_if, bbs_ram, bbs_outq and bbs_ctrl.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Contents
// in_ch     sink       command (3 bits), push_value (8 bits)
// out_ch    source     item (8 bits), last (1 bit)
// cfg_*     input      cfg_we, cfg_wdata: capacity (7 bits)
//
// Push, pop and ignored commands are accepted back to back.
// A peek or dump of n entries holds off input while the read sequencer walks
// the entry memory, one synchronous read a cycle while the result queue has room;
// each result reaches out_ch through the memory read register and then the queue
// register. A stalled out_ch pauses the reads through the two-entry result
// queue, and no result is ever dropped.
// Reset empties the stack and sets capacity to 64; the entry memory needs no
// clearing, since entries above the fill count are never read.
module bounded_byte_stack (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  bbs_cmd_if.sink                        in_ch,
  bbs_res_if.source                      out_ch,
  input  wire logic                      cfg_we,
  input  wire logic [bbs_pkg::CAP_W-1:0] cfg_wdata
);

  bbs_pkg::mem_wr_t           wr;
  bbs_pkg::rd_issue_t         issue;
  bbs_pkg::q_status_t         status;
  logic [bbs_pkg::DATA_W-1:0] rdata;

  // The controller decodes each command item, keeps the fill count and
  // capacity, and sequences reads for peek and both dumps.
  bbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .status    (status),
    .wr        (wr),
    .issue     (issue)
  );

  // Entry memory; index 0 is the base of the stack.
  bbs_ram #(
    .DEPTH (bbs_pkg::DEPTH),
    .WIDTH (bbs_pkg::DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (wr.we),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (issue.re),
    .raddr (issue.addr),
    .rdata (rdata)
  );

  // The result queue only grants a read when a slot will be free for its data.
  bbs_outq u_outq (
    .clk    (clk),
    .rst_n  (rst_n),
    .issue  (issue),
    .rdata  (rdata),
    .out_ch (out_ch),
    .status (status)
  );

endmodule

`default_nettype wire
